### sv/pure_pursuit_steering_core_defines.svh
// Assertion macros shared by the pure pursuit steering core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PURE_PURSUIT_STEERING_CORE_DEFINES_SVH
`define PURE_PURSUIT_STEERING_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PPSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pure pursuit steering core: check failed");

// Next-cycle implication, disabled while reset is low.
`define PPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pure pursuit steering core: check failed");

`endif

### sv/ppsc_pkg.sv
// Package for the pure pursuit steering core: shared types, widths and constants.
// Used by ppsc_muldiv and pure_pursuit_steering_core; depends on nothing.
package ppsc_pkg;

    localparam int MD_W   = 32;
    localparam int MD_PW  = 64;
    localparam int CNT_W  = 6;

    typedef enum logic {
        MD_MUL,
        MD_DIV
    } t_md_op;

    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_req;

    localparam int LEN_W   = 24;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam int SQ_W    = 63;
    localparam logic [SQ_W-1:0] SQ_SAT = 63'h4000_0000_0000_0000;
    localparam int CX_W    = 64;
    localparam int Z_W     = 23;
    localparam int ANG_W   = 16;
    localparam int CORDIC_STEPS = 20;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_LAST   = 2'd1;
    localparam logic [1:0] ST_CLOSE  = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    function automatic logic [19:0] atan_val(input logic [4:0] idx);
        logic [19:0] v;
        case (idx)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/ppsc_muldiv.sv
// Bit-serial unsigned multiplier (32x32) and restoring divider (64/32).
// Depends on ppsc_pkg.
module ppsc_muldiv import ppsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_md_req          i_req,
    input  logic [MD_PW-1:0] i_a,
    input  logic [MD_W-1:0]  i_b,
    output logic             o_done,
    output logic [MD_PW-1:0] o_res
);

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } t_ustate;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MD_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MD_PW - 1);

    t_ustate            r_st;
    logic               r_done;
    t_md_op             r_op;
    logic [CNT_W-1:0]   r_cnt;
    logic [MD_PW-1:0]   r_acc;
    logic [MD_PW-1:0]   r_mcand;
    logic [MD_W-1:0]    r_mplier;
    logic [MD_PW-1:0]   r_quo;
    logic [MD_W:0]      r_rem;
    logic [MD_W-1:0]    r_dvs;

    logic [MD_W:0]      c_trial;
    logic               c_ge;
    logic [MD_W:0]      c_diff;

    assign c_trial = {r_rem[MD_W-1:0], r_quo[MD_PW-1]};
    assign c_ge    = c_trial >= {1'b0, r_dvs};
    assign c_diff  = c_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= U_IDLE;
            r_done <= 1'b0;
        end else begin
            case (r_st)
                U_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_op  <= i_req.op;
                        r_cnt <= '0;
                        if (i_req.op == MD_MUL) begin
                            r_acc    <= '0;
                            r_mcand  <= MD_PW'(i_a[MD_W-1:0]);
                            r_mplier <= i_b;
                            r_st     <= U_MUL;
                        end else begin
                            r_quo <= i_a;
                            r_rem <= '0;
                            r_dvs <= i_b;
                            r_st  <= U_DIV;
                        end
                    end
                end
                U_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= {r_mcand[MD_PW-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[MD_W-1:1]};
                    r_cnt    <= r_cnt + 1'b1;
                    r_done   <= (r_cnt == MUL_LAST);
                    if (r_cnt == MUL_LAST) begin
                        r_st <= U_IDLE;
                    end
                end
                U_DIV: begin
                    r_rem  <= c_ge ? c_diff : c_trial;
                    r_quo  <= {r_quo[MD_PW-2:0], c_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    r_done <= (r_cnt == DIV_LAST);
                    if (r_cnt == DIV_LAST) begin
                        r_st <= U_IDLE;
                    end
                end
                default: begin
                    r_st   <= U_IDLE;
                    r_done <= 1'b0;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == MD_MUL) ? r_acc : r_quo;

endmodule

### sv/pure_pursuit_steering_core.sv
// Pure pursuit steering core: top level with the path sequencer and result register.
// Depends on ppsc_pkg, ppsc_muldiv and pure_pursuit_steering_core_defines.svh.
//
// Path points stream in one per transaction; the speed of the first transaction of a path
// sets the look-ahead distance, and the transaction flagged by tlast returns one result with
// the steering angle, a status code and the chosen target. Each transaction is processed to
// completion before the next one is taken: a point that adds a segment takes two squarings
// and a 32-step square root, a segment that needs interpolation two more multiplies and two
// divides, and the closing transaction adds up to three multiplies, a normalizing shift of
// one bit per cycle and 20 CORDIC steps. All arithmetic runs on the single bit-serial multiply
// and divide unit and the one-step-per-cycle loops. A finished result waits in the output
// register while the next path point is taken.
`include "pure_pursuit_steering_core_defines.svh"

module pure_pursuit_steering_core import ppsc_pkg::*; #(
    parameter int COORD_WIDTH = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // pos_x, pos_y, speed, zero fill
    input  logic [((2*COORD_WIDTH+15+7)/8)*8-1:0] i_s_axis_tdata,
    // point_present
    input  logic                 i_s_axis_tuser,
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // steering, status, target_x, target_y, zero fill
    output logic [((2*COORD_WIDTH+18+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_TW = ((2*COORD_WIDTH+18+7)/8)*8;

    localparam logic [1:0] CFG_LA_A = 2'd0;
    localparam logic [1:0] CFG_GAIN = 2'd1;
    localparam logic [1:0] CFG_LA_B = 2'd2;
    localparam logic [1:0] CFG_WB   = 2'd3;

    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_BEGIN, S_POINT, S_WAIT, S_SQY, S_SUM, S_SQRT, S_ACC,
        S_IXD, S_IXQ, S_IYD, S_IYQ, S_UPD, S_FIN, S_FSQ, S_FDEN, S_FNUM,
        S_NORM, S_CORD, S_RND, S_EMIT
    } t_state;

    t_state                 r_state;
    t_state                 r_ret;

    logic [15:0]            r_cfg_a;
    logic [11:0]            r_cfg_g;
    logic [15:0]            r_cfg_b;
    logic [12:0]            r_cfg_wb;

    logic signed [CW-1:0]   r_sx;
    logic signed [CW-1:0]   r_sy;
    logic                   r_pp;
    logic                   r_lp;
    logic signed [14:0]     r_spd;

    logic signed [CW-1:0]   r_prev_x;
    logic signed [CW-1:0]   r_prev_y;
    logic [LEN_W-1:0]       r_plen;
    logic signed [LEN_W-1:0] r_la;
    logic                   r_found;
    logic signed [CW-1:0]   r_tgt_x;
    logic signed [CW-1:0]   r_tgt_y;
    logic                   r_in_path;
    logic                   r_have;

    logic [CW-1:0]          r_adx;
    logic [CW-1:0]          r_ady;
    logic                   r_dxneg;
    logic                   r_dyneg;
    logic [MD_PW-1:0]       r_sq;
    logic [SQ_W-1:0]        r_s2;
    logic [SQ_W-1:0]        r_sv;
    logic [MD_PW-1:0]       r_sr;
    logic [SQ_W-1:0]        r_sbit;
    logic [MD_W-1:0]        r_seg;
    logic [LEN_W-1:0]       r_num;

    logic signed [CW-1:0]   r_tx;
    logic signed [CW-1:0]   r_ty;
    logic [SQ_W-1:0]        r_big;
    logic signed [CX_W-1:0] r_cx;
    logic signed [CX_W-1:0] r_cy;
    logic signed [Z_W-1:0]  r_z;
    logic [4:0]             r_i;
    logic [1:0]             r_status;
    logic signed [ANG_W-1:0] r_steer;

    logic                   r_ovalid;
    logic signed [ANG_W-1:0] r_o_steer;
    logic [1:0]             r_o_status;
    logic signed [CW-1:0]   r_o_tx;
    logic signed [CW-1:0]   r_o_ty;

    t_md_req                c_req;
    logic [MD_PW-1:0]       c_md_a;
    logic [MD_W-1:0]        c_md_b;
    logic                   md_done;
    logic [MD_PW-1:0]       md_res;

    logic signed [27:0]     c_la_prod;
    logic signed [LEN_W-1:0] c_la_sh;
    logic signed [LEN_W-1:0] c_la;

    logic signed [CW:0]     c_dx;
    logic signed [CW:0]     c_dy;
    logic [CW:0]            c_adx_w;
    logic [CW:0]            c_ady_w;
    logic [CW-1:0]          c_adx;
    logic [CW-1:0]          c_ady;
    logic                   c_seg_go;

    logic [CW-1:0]          c_sq_ma;
    logic [CW-1:0]          c_sq_mb;
    logic                   c_sq_big;
    logic [MD_PW:0]         c_sq_sum;
    logic [SQ_W-1:0]        c_sumsq;

    logic [MD_PW-1:0]       c_rb;
    logic                   c_sge;
    logic [SQ_W-1:0]        n_sv;
    logic [MD_PW-1:0]       n_sr;

    logic [LEN_W:0]         c_acc_sum;
    logic [LEN_W-1:0]       c_acc;
    logic                   c_hit;
    logic [LEN_W-1:0]       c_before;
    logic signed [LEN_W+1:0] c_num;
    logic                   c_num_le0;
    logic                   c_num_ge;
    logic                   c_interp;

    logic [CW-1:0]          c_qm;
    logic [CW-1:0]          c_q;

    logic signed [CW-1:0]   c_tx;
    logic [CW-1:0]          c_amc;
    logic [CW-1:0]          c_amx;
    logic [CW-1:0]          c_amy;
    logic                   c_close;
    logic [CX_W-1:0]        c_p2;

    logic signed [CX_W-1:0] c_shx;
    logic signed [CX_W-1:0] c_shy;
    logic signed [Z_W-1:0]  c_at;
    logic [Z_W-1:0]         c_zabs;
    logic [Z_W-1:0]         c_zrnd;
    logic [ANG_W-1:0]       c_rnd;

    ppsc_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_req),
        .i_a     (c_md_a),
        .i_b     (c_md_b),
        .o_done  (md_done),
        .o_res   (md_res)
    );

    assign c_la_prod = $signed({1'b0, r_cfg_g}) * r_spd;
    assign c_la_sh   = LEN_W'(c_la_prod >>> 6);
    assign c_la      = $signed({8'd0, r_cfg_a}) + $signed({8'd0, r_cfg_b}) + c_la_sh;

    assign c_dx     = {r_sx[CW-1], r_sx} - {r_prev_x[CW-1], r_prev_x};
    assign c_dy     = {r_sy[CW-1], r_sy} - {r_prev_y[CW-1], r_prev_y};
    assign c_adx_w  = c_dx[CW] ? -c_dx : c_dx;
    assign c_ady_w  = c_dy[CW] ? -c_dy : c_dy;
    assign c_adx    = c_adx_w[CW-1:0];
    assign c_ady    = c_ady_w[CW-1:0];
    assign c_seg_go = r_pp && r_have && !r_found;

    assign c_tx  = r_found ? r_tgt_x : r_prev_x;
    assign c_amc = c_tx[CW-1] ? -c_tx : c_tx;
    assign c_amx = r_tx[CW-1] ? -r_tx : r_tx;
    assign c_amy = r_ty[CW-1] ? -r_ty : r_ty;

    assign c_sq_ma  = (r_state == S_SUM) ? r_adx : c_amx;
    assign c_sq_mb  = (r_state == S_SUM) ? r_ady : c_amy;
    assign c_sq_big = (33'(c_sq_ma) > 33'h0_7FFF_FFFF) || (33'(c_sq_mb) > 33'h0_7FFF_FFFF);
    assign c_sq_sum = {1'b0, r_sq} + {1'b0, md_res};
    assign c_sumsq  = (c_sq_big || c_sq_sum > (MD_PW+1)'(SQ_SAT)) ? SQ_SAT
                                                                  : c_sq_sum[SQ_W-1:0];
    assign c_close  = c_sumsq <= SQ_W'(1);

    assign c_rb  = r_sr + {1'b0, r_sbit};
    assign c_sge = {1'b0, r_sv} >= c_rb;
    assign n_sv  = c_sge ? r_sv - c_rb[SQ_W-1:0] : r_sv;
    assign n_sr  = c_sge ? {1'b0, r_sr[MD_PW-1:1]} + {1'b0, r_sbit}
                         : {1'b0, r_sr[MD_PW-1:1]};

    assign c_acc_sum = {1'b0, r_plen} + {1'b0, r_seg[LEN_W-1:0]};
    assign c_acc     = (r_seg[MD_W-1:LEN_W] != '0 || c_acc_sum[LEN_W]) ? LEN_MAX
                                                                        : c_acc_sum[LEN_W-1:0];
    assign c_hit     = ($signed({1'b0, c_acc}) >= $signed({r_la[LEN_W-1], r_la}))
                       && (r_s2 >= SQ_W'(2));
    assign c_before  = (MD_W'(c_acc) > r_seg) ? c_acc - r_seg[LEN_W-1:0] : '0;
    assign c_num     = $signed({{2{r_la[LEN_W-1]}}, r_la}) - $signed({2'b00, c_before});
    assign c_num_le0 = c_num[LEN_W+1] || (c_num == '0);
    assign c_num_ge  = !c_num[LEN_W+1] && (MD_W'(c_num[LEN_W:0]) >= r_seg);
    assign c_interp  = c_hit && !c_num_le0 && !c_num_ge;

    assign c_qm = (r_state == S_IXQ) ? r_adx : r_ady;
    assign c_q  = (md_res > MD_PW'(c_qm)) ? c_qm : md_res[CW-1:0];

    assign c_p2  = {md_res[CX_W-2:0], 1'b0};

    assign c_shx  = r_cx >>> r_i;
    assign c_shy  = r_cy >>> r_i;
    assign c_at   = $signed({3'b000, atan_val(r_i)});
    assign c_zabs = r_z[Z_W-1] ? -r_z : r_z;
    assign c_zrnd = (c_zabs + Z_W'(64)) >> 7;
    assign c_rnd  = c_zrnd[ANG_W-1:0];

    always_comb begin
        c_req.start = 1'b0;
        c_req.op    = MD_MUL;
        c_md_a      = '0;
        c_md_b      = '0;
        case (r_state)
            S_POINT: begin
                c_req.start = c_seg_go;
                c_md_a      = MD_PW'(c_adx);
                c_md_b      = MD_W'(c_adx);
            end
            S_SQY: begin
                c_req.start = 1'b1;
                c_md_a      = MD_PW'(r_ady);
                c_md_b      = MD_W'(r_ady);
            end
            S_ACC: begin
                c_req.start = c_interp;
                c_md_a      = MD_PW'(c_num[LEN_W-1:0]);
                c_md_b      = MD_W'(r_adx);
            end
            S_IXD, S_IYD: begin
                c_req.start = 1'b1;
                c_req.op    = MD_DIV;
                c_md_a      = md_res + MD_PW'(r_seg >> 1);
                c_md_b      = r_seg;
            end
            S_IXQ: begin
                c_req.start = 1'b1;
                c_md_a      = MD_PW'(r_num);
                c_md_b      = MD_W'(r_ady);
            end
            S_FIN: begin
                c_req.start = r_have;
                c_md_a      = MD_PW'(c_amc);
                c_md_b      = MD_W'(c_amc);
            end
            S_FSQ: begin
                c_req.start = 1'b1;
                c_md_a      = MD_PW'(c_amy);
                c_md_b      = MD_W'(c_amy);
            end
            S_FDEN: begin
                c_req.start = !c_close;
                c_md_a      = MD_PW'(c_amy);
                c_md_b      = MD_W'(r_cfg_wb);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_cfg_a   <= 16'd2048;
            r_cfg_g   <= 12'd256;
            r_cfg_b   <= 16'd0;
            r_cfg_wb  <= 13'd2765;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_plen    <= '0;
            r_la      <= '0;
            r_found   <= 1'b0;
            r_tgt_x   <= '0;
            r_tgt_y   <= '0;
            r_in_path <= 1'b0;
            r_have    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LA_A: r_cfg_a  <= i_cfg_wdata;
                    CFG_GAIN: r_cfg_g  <= i_cfg_wdata[11:0];
                    CFG_LA_B: r_cfg_b  <= i_cfg_wdata;
                    CFG_WB:   r_cfg_wb <= i_cfg_wdata[12:0];
                    default:  ;
                endcase
            end
            if (r_ovalid && i_m_axis_tready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_sx    <= $signed(i_s_axis_tdata[CW-1:0]);
                        r_sy    <= $signed(i_s_axis_tdata[2*CW-1:CW]);
                        r_spd   <= $signed(i_s_axis_tdata[2*CW+14:2*CW]);
                        r_pp    <= i_s_axis_tuser;
                        r_lp    <= i_s_axis_tlast;
                        r_state <= S_BEGIN;
                    end
                end
                S_BEGIN: begin
                    if (!r_in_path) begin
                        r_la      <= c_la;
                        r_plen    <= '0;
                        r_found   <= 1'b0;
                        r_have    <= 1'b0;
                        r_in_path <= 1'b1;
                    end
                    r_state <= S_POINT;
                end
                S_POINT: begin
                    r_adx   <= c_adx;
                    r_ady   <= c_ady;
                    r_dxneg <= c_dx[CW];
                    r_dyneg <= c_dy[CW];
                    if (c_seg_go) begin
                        r_ret   <= S_SQY;
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_WAIT: begin
                    if (md_done) begin
                        r_state <= r_ret;
                    end
                end
                S_SQY: begin
                    r_sq    <= md_res;
                    r_ret   <= S_SUM;
                    r_state <= S_WAIT;
                end
                S_SUM: begin
                    r_s2    <= c_sumsq;
                    r_sv    <= c_sumsq;
                    r_sr    <= '0;
                    r_sbit  <= SQ_SAT;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_sv   <= n_sv;
                    r_sr   <= n_sr;
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit[0]) begin
                        r_seg   <= n_sr[MD_W-1:0];
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_plen <= c_acc;
                    r_num  <= c_num[LEN_W-1:0];
                    if (c_interp) begin
                        r_ret   <= S_IXD;
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_UPD;
                    end
                    if (c_hit) begin
                        if (c_num_le0) begin
                            r_tgt_x <= r_prev_x;
                            r_tgt_y <= r_prev_y;
                            r_found <= 1'b1;
                        end else if (c_num_ge) begin
                            r_tgt_x <= r_sx;
                            r_tgt_y <= r_sy;
                            r_found <= 1'b1;
                        end
                    end
                end
                S_IXD: begin
                    r_ret   <= S_IXQ;
                    r_state <= S_WAIT;
                end
                S_IXQ: begin
                    r_tgt_x <= r_dxneg ? r_prev_x - $signed(c_q) : r_prev_x + $signed(c_q);
                    r_ret   <= S_IYD;
                    r_state <= S_WAIT;
                end
                S_IYD: begin
                    r_ret   <= S_IYQ;
                    r_state <= S_WAIT;
                end
                S_IYQ: begin
                    r_tgt_y <= r_dyneg ? r_prev_y - $signed(c_q) : r_prev_y + $signed(c_q);
                    r_found <= 1'b1;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_pp) begin
                        r_prev_x <= r_sx;
                        r_prev_y <= r_sy;
                        r_have   <= 1'b1;
                    end
                    if (r_lp) begin
                        r_in_path <= 1'b0;
                        r_state   <= S_FIN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FIN: begin
                    r_steer <= '0;
                    if (!r_have) begin
                        r_tx     <= '0;
                        r_ty     <= '0;
                        r_status <= ST_EMPTY;
                        r_state  <= S_EMIT;
                    end else begin
                        r_tx     <= c_tx;
                        r_ty     <= r_found ? r_tgt_y : r_prev_y;
                        r_status <= r_found ? ST_INTERP : ST_LAST;
                        r_ret    <= S_FSQ;
                        r_state  <= S_WAIT;
                    end
                end
                S_FSQ: begin
                    r_sq    <= md_res;
                    r_ret   <= S_FDEN;
                    r_state <= S_WAIT;
                end
                S_FDEN: begin
                    r_cx <= $signed(CX_W'(c_sumsq));
                    if (c_close) begin
                        r_status <= ST_CLOSE;
                        r_state  <= S_EMIT;
                    end else begin
                        r_ret   <= S_FNUM;
                        r_state <= S_WAIT;
                    end
                end
                S_FNUM: begin
                    r_cy    <= r_ty[CW-1] ? -$signed(c_p2) : $signed(c_p2);
                    r_big   <= (c_p2[SQ_W-1:0] > r_cx[SQ_W-1:0]) ? c_p2[SQ_W-1:0]
                                                                  : r_cx[SQ_W-1:0];
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_big[SQ_W-1:39] != '0) begin
                        r_cx  <= r_cx >>> 1;
                        r_cy  <= r_cy >>> 1;
                        r_big <= r_big >> 1;
                    end else if (r_big[38] == 1'b0) begin
                        r_cx  <= r_cx <<< 1;
                        r_cy  <= r_cy <<< 1;
                        r_big <= r_big << 1;
                    end else begin
                        r_z     <= '0;
                        r_i     <= '0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (!r_cy[CX_W-1]) begin
                        r_cx <= r_cx + c_shy;
                        r_cy <= r_cy - c_shx;
                        r_z  <= r_z + c_at;
                    end else begin
                        r_cx <= r_cx - c_shy;
                        r_cy <= r_cy + c_shx;
                        r_z  <= r_z - c_at;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == CORDIC_LAST) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_steer <= r_z[Z_W-1] ? -$signed(c_rnd) : $signed(c_rnd);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid   <= 1'b1;
                        r_o_steer  <= r_steer;
                        r_o_status <= r_status;
                        r_o_tx     <= r_tx;
                        r_o_ty     <= r_ty;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_TW'({r_o_ty, r_o_tx, r_o_status, r_o_steer});

    `PPSC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `PPSC_ASSERT_NOW(a_md_done_in_wait, i_clk, i_rst_n, md_done, r_state == S_WAIT)
    `PPSC_ASSERT_NOW(a_close_zero, i_clk, i_rst_n, o_m_axis_tvalid && r_o_status == ST_CLOSE, r_o_steer == '0)
    `PPSC_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_m_axis_tvalid && r_o_status == ST_EMPTY, r_o_tx == '0 && r_o_ty == '0 && r_o_steer == '0)

endmodule

### tb/sv/tb_pure_pursuit_steering_core.sv
// Testbench for pure_pursuit_steering_core: streams directed and random paths, predicts
// each steering result in a scoreboard class and checks every result transaction.
// Depends on ppsc_pkg and the RTL of pure_pursuit_steering_core only.
module tb_pure_pursuit_steering_core;
    import ppsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        REG_OFFSET_A   = 2'd0,
        REG_SPEED_GAIN = 2'd1,
        REG_OFFSET_B   = 2'd2,
        REG_BASE_LEN   = 2'd3
    } t_reg_index;

    typedef struct {
        logic [15:0] steering;
        logic [1:0]  status;
        logic [19:0] goal_x;
        logic [19:0] goal_y;
    } t_steer_result;

    class steering_scoreboard;
        longint unsigned offset_a, speed_gain, offset_b, base_len;
        longint          last_x, last_y, look_dist, aim_x, aim_y;
        longint unsigned summed_len;
        bit              aim_found, mid_path, any_point;
        t_steer_result   pending_results[$];
        int              errors, checked, paths;

        function new();
            offset_a   = 2048;
            speed_gain = 256;
            offset_b   = 0;
            base_len   = 2765;
            last_x = 0; last_y = 0; look_dist = 0; aim_x = 0; aim_y = 0;
            summed_len = 0;
            aim_found = 0; mid_path = 0; any_point = 0;
            errors = 0; checked = 0; paths = 0;
        endfunction

        function void set_register(t_reg_index idx, logic [15:0] value);
            case (idx)
                REG_OFFSET_A:   offset_a   = 64'(value);
                REG_SPEED_GAIN: speed_gain = 64'(value[11:0]);
                REG_OFFSET_B:   offset_b   = 64'(value);
                REG_BASE_LEN:   base_len   = 64'(value[12:0]);
                default:        ;
            endcase
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function longint unsigned square_sum(longint unsigned a, longint unsigned b);
            longint unsigned s;
            if (a > 64'h7FFF_FFFF || b > 64'h7FFF_FFFF) return 64'h4000_0000_0000_0000;
            s = a * a + b * b;
            return (s > 64'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : s;
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r, bitv;
            r = 0;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= r + bitv) begin
                    v = v - (r + bitv);
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
            return r;
        endfunction

        function longint lerp_axis(longint start, longint d, longint unsigned num,
                                   longint unsigned seg);
            longint unsigned m, q;
            m = magnitude(d);
            q = (num * m + seg / 2) / seg;
            if (q > m) q = m;
            return (d < 0) ? start - longint'(q) : start + longint'(q);
        endfunction

        function longint steer_angle(longint num, longint den);
            longint x, y, z, nx;
            longint unsigned big, r;
            longint atan_step[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                      8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
                                      8, 4, 2};
            x = den; y = num; z = 0;
            big = (magnitude(y) > magnitude(x)) ? magnitude(y) : magnitude(x);
            while (big >= (64'd1 << 39)) begin
                x = x >>> 1; y = y >>> 1; big = big >> 1;
            end
            while (big != 0 && big < (64'd1 << 38)) begin
                x = x * 2; y = y * 2; big = big << 1;
            end
            for (int i = 0; i < 20; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_step[i];
                end else begin
                    nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_step[i];
                end
                x = nx;
            end
            r = (magnitude(z) + 64) >> 7;
            return (z < 0) ? -longint'(r) : longint'(r);
        endfunction

        function void note_item(logic [19:0] px, logic [19:0] py, bit present, bit last,
                                logic [14:0] spd);
            longint sx, sy, dx, dy, prod, num, tx, ty, steer;
            longint unsigned s2, seg, acc, start_len;
            logic [1:0] status;
            t_steer_result res;
            sx = longint'($signed(px));
            sy = longint'($signed(py));
            if (!mid_path) begin
                prod = longint'(speed_gain) * longint'($signed(spd));
                prod = prod >>> 6;
                look_dist = longint'(offset_a) + longint'(offset_b) + prod;
                summed_len = 0;
                aim_found = 0;
                any_point = 0;
                mid_path = 1;
            end
            if (present) begin
                if (any_point && !aim_found) begin
                    dx = sx - last_x;
                    dy = sy - last_y;
                    s2 = square_sum(magnitude(dx), magnitude(dy));
                    seg = root_floor(s2);
                    acc = summed_len + seg;
                    if (acc > 64'hFF_FFFF) acc = 64'hFF_FFFF;
                    summed_len = acc;
                    if (longint'(acc) >= look_dist && s2 >= 2) begin
                        start_len = (acc > seg) ? acc - seg : 0;
                        num = look_dist - longint'(start_len);
                        if (num <= 0) begin
                            aim_x = last_x; aim_y = last_y;
                        end else if (longint'(num) >= longint'(seg)) begin
                            aim_x = sx; aim_y = sy;
                        end else begin
                            aim_x = lerp_axis(last_x, dx, num, seg);
                            aim_y = lerp_axis(last_y, dy, num, seg);
                        end
                        aim_found = 1;
                    end
                end
                last_x = sx;
                last_y = sy;
                any_point = 1;
            end
            if (!last) return;
            mid_path = 0;
            paths++;
            tx = 0; ty = 0; steer = 0;
            if (!any_point) begin
                status = ST_EMPTY;
            end else begin
                if (aim_found) begin
                    tx = aim_x; ty = aim_y; status = ST_INTERP;
                end else begin
                    tx = last_x; ty = last_y; status = ST_LAST;
                end
                if (square_sum(magnitude(tx), magnitude(ty)) <= 1) begin
                    status = ST_CLOSE;
                end else begin
                    steer = steer_angle(2 * longint'(base_len) * ty,
                                        longint'(square_sum(magnitude(tx), magnitude(ty))));
                end
            end
            res.steering = steer[15:0];
            res.status   = status;
            res.goal_x   = tx[19:0];
            res.goal_y   = ty[19:0];
            pending_results.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [63:0] d);
            t_steer_result want;
            checked++;
            if (pending_results.size() == 0) begin
                report("unexpected result", d, 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (d[15:0] !== want.steering)
                report("steering", 64'(d[15:0]), 64'(want.steering));
            if (d[17:16] !== want.status)
                report("status", 64'(d[17:16]), 64'(want.status));
            if (d[37:18] !== want.goal_x)
                report("goal_x", 64'(d[37:18]), 64'(want.goal_x));
            if (d[57:38] !== want.goal_y)
                report("goal_y", 64'(d[57:38]), 64'(want.goal_y));
        endtask
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;

    steering_scoreboard sb = new();
    bit quiet = 0;
    int items_sent = 0;
    int config_phases = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    pure_pursuit_steering_core uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_item(i_s_axis_tdata[19:0], i_s_axis_tdata[39:20], i_s_axis_tuser,
                             i_s_axis_tlast, i_s_axis_tdata[54:40]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || i_cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 13);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task send(logic [19:0] px, logic [19:0] py, bit present, bit last, logic [14:0] spd);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, spd, py, px};
        i_s_axis_tuser  <= present;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task drain(bit settle);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task set_config(logic [15:0] a, logic [15:0] g, logic [15:0] b, logic [15:0] w);
        t_reg_index idx;
        logic [15:0] vals[4];
        vals = '{a, g, b, w};
        drain(1);
        for (int i = 0; i < 4; i++) begin
            idx = t_reg_index'(i);
            @(negedge i_clk);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_wdata <= vals[i];
            sb.set_register(idx, vals[i]);
        end
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        config_phases++;
    endtask

    task random_path(bit noise);
        int n;
        logic [19:0] x, y;
        logic [14:0] spd;
        bit present;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
        spd = 15'($urandom);
        x = 20'(int'($urandom_range(0, 4000)) - 2000);
        y = 20'(int'($urandom_range(0, 4000)) - 2000);
        for (int i = 0; i < n; i++) begin
            if (noise) begin
                x = 20'($urandom);
                y = 20'($urandom);
                present = $urandom_range(0, 3) != 0;
            end else begin
                x = x + 20'($urandom_range(0, 3000));
                y = y + 20'(int'($urandom_range(0, 2000)) - 1000);
                present = $urandom_range(0, 9) != 0;
            end
            send(x, y, present, i == n - 1, spd);
            spd = 15'($urandom);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed paths with reset register values.
        send(20'd0, 20'd0, 1'b0, 1'b1, 15'd0);
        send(20'd1000, -20'sd500, 1'b1, 1'b1, 15'd100);
        send(20'd1, 20'd0, 1'b1, 1'b1, 15'd0);
        send(20'd0, 20'd0, 1'b1, 1'b1, 15'd0);
        send(20'h80000, 20'h80000, 1'b1, 1'b0, 15'h4000);
        send(20'h7FFFF, 20'h7FFFF, 1'b1, 1'b1, 15'h3FFF);
        send(20'd0, 20'd0, 1'b0, 1'b0, 15'd5000);
        send(20'd0, 20'd0, 1'b1, 1'b0, 15'd0);
        send(20'd4096, 20'd0, 1'b1, 1'b1, 15'd0);
        send(20'd0, 20'd0, 1'b1, 1'b0, 15'd0);
        send(20'd4096, 20'd300, 1'b1, 1'b0, 15'd0);
        send(20'd8000, 20'd100, 1'b1, 1'b0, 15'd0);
        send(20'd9000, 20'd0, 1'b1, 1'b1, 15'd0);
        send(20'd100, 20'd100, 1'b1, 1'b0, 15'd0);
        send(20'd100, 20'd100, 1'b1, 1'b0, 15'd0);
        send(20'd101, 20'd100, 1'b1, 1'b1, 15'd0);

        set_config(16'hFFFF, 16'h0FFF, 16'hFFFF, 16'h1FFF);
        send(20'd0, 20'd0, 1'b1, 1'b0, 15'h4000);
        send(20'd10, 20'd5, 1'b1, 1'b0, 15'd0);
        send(20'd50, -20'sd7, 1'b1, 1'b1, 15'd0);
        send(20'h80000, 20'h7FFFF, 1'b1, 1'b0, 15'h3FFF);
        send(20'h7FFFF, 20'h80000, 1'b1, 1'b1, 15'd0);

        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        send(20'd0, 20'd0, 1'b1, 1'b0, 15'd77);
        send(20'd3, 20'd900, 1'b1, 1'b1, 15'd0);

        set_config(16'd2048, 16'd256, 16'd0, 16'd2765);
        while (items_sent < 1600) begin
            if (items_sent > 1400) quiet = 1;
            random_path($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 39) == 0) drain(0);
            if ($urandom_range(0, 59) == 0)
                set_config(16'($urandom_range(0, 8000)), 16'($urandom),
                           16'($urandom_range(0, 8000)), 16'($urandom));
        end
        drain(1);
        $display("run covered %0d transactions in %0d paths over %0d register settings",
                 items_sent, sb.paths, config_phases);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
